// ===== rtl/core/apnc_pkg.sv =====
package apnc_pkg;

    // verdict codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_EMPTY     = 4'd1;
    localparam logic [3:0] ST_EMPTY_DIR = 4'd2;
    localparam logic [3:0] ST_ABSOLUTE  = 4'd3;
    localparam logic [3:0] ST_DRIVE     = 4'd4;
    localparam logic [3:0] ST_EMPTY_SEG = 4'd5;
    localparam logic [3:0] ST_DOT_SEG   = 4'd6;
    localparam logic [3:0] ST_NUL       = 4'd7;
    localparam logic [3:0] ST_BACKSLASH = 4'd8;
    localparam logic [3:0] ST_BAD_CHAR  = 4'd9;
    localparam logic [3:0] ST_TRAILING  = 4'd10;
    localparam logic [3:0] ST_RESERVED  = 4'd11;

    localparam int STEM_DEPTH = 4;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
        logic       empty_entry;
    } t_in_req;

    typedef struct packed {
        logic [3:0] status;
        logic       is_directory;
    } t_out_req;

    // what the end-of-segment rules look at
    typedef struct packed {
        logic [2:0]                  seg_len;
        logic                        all_dots;
        logic [2:0]                  stem_len;
        logic [STEM_DEPTH-1:0][7:0]  stem_chars;
        logic [7:0]                  last_char;
    } t_seg_info;

endpackage

// ===== rtl/core/archive_path_name_checker.sv =====
// archive entry name checker
// in channel: one request per name byte (i_in_valid / o_in_ready, payload i_in_req);
//   last_byte marks the end of a name, empty_entry stands for a zero-length name and
//   drops any partial name
// out channel: one verdict request (o_out_valid / i_out_ready, payload o_out_req)
//   per name: status is ok or the first violation seen, is_directory for a
//   trailing slash
// cfg channel: i_cfg_valid / o_cfg_ready with i_cfg_data = target_windows, always
//   ready; write it only while no name is in flight
// latency: the verdict shows one cycle after the last byte is accepted
// throughput: one byte per cycle; all checks run in one combinational pass
//   between the accepted byte and the verdict register
// stall: while a verdict waits and i_out_ready is low, o_in_ready drops; when the
//   verdict is taken in the same cycle a new byte is still accepted
// reset (synchronous, active low): no verdict pending, name state cleared,
//   target_windows off
module archive_path_name_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  apnc_pkg::t_in_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output apnc_pkg::t_out_req o_out_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);
    import apnc_pkg::*;

    // config
    logic r_target_windows;

    // per-name state
    logic [3:0]                 r_first_error, n_first_error;
    logic [1:0]                 r_name_pos,    n_name_pos;
    logic                       r_first_letter, n_first_letter;
    logic [2:0]                 r_seg_len,     n_seg_len;
    logic                       r_all_dots,    n_all_dots;
    logic [STEM_DEPTH-1:0][7:0] r_stem_chars,  n_stem_chars;
    logic [2:0]                 r_stem_len,    n_stem_len;
    logic                       r_stem_closed, n_stem_closed;
    logic [7:0]                 r_prev_byte,   n_prev_byte;

    // verdict register
    logic     r_out_valid;
    t_out_req r_out_req, n_out_req;

    // byte decode
    logic       w_accept;
    logic       w_result;
    logic [7:0] w_byte;
    logic       w_is_slash;
    logic       w_is_dot;
    logic       w_is_lower;
    logic       w_is_letter;
    logic [7:0] w_upper;
    logic       w_win_bad;
    logic [3:0] w_byte_code;

    // state after this byte, before the end-of-name clear
    logic [2:0]                 w_upd_seg_len;
    logic                       w_upd_all_dots;
    logic [STEM_DEPTH-1:0][7:0] w_upd_stem_chars;
    logic [2:0]                 w_upd_stem_len;
    logic                       w_upd_stem_closed;
    logic [7:0]                 w_upd_prev_byte;
    logic                       w_upd_first_letter;

    t_seg_info  w_seg;
    logic [3:0] w_seg_code;

    assign o_cfg_ready = 1'b1;

    // a byte goes in whenever the verdict slot is free or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_result    = i_in_req.empty_entry || i_in_req.last_byte;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign w_byte      = i_in_req.name_byte;
    assign w_is_slash  = (w_byte == "/");
    assign w_is_dot    = (w_byte == ".");
    assign w_is_lower  = (w_byte >= "a") && (w_byte <= "z");
    assign w_is_letter = w_is_lower || ((w_byte >= "A") && (w_byte <= "Z"));
    assign w_upper     = w_is_lower ? (w_byte - 8'd32) : w_byte;
    assign w_win_bad   = (w_byte < 8'h20) || (w_byte == "<") || (w_byte == ">") ||
                         (w_byte == ":") || (w_byte == "\"") || (w_byte == "|") ||
                         (w_byte == "?") || (w_byte == "*");

    // per-byte violation: drive prefix first, then forbidden bytes
    always_comb begin
        priority if ((r_name_pos == 2'd1) && (w_byte == ":") && r_first_letter) begin
            w_byte_code = ST_DRIVE;
        end else if (w_byte == 8'h00) begin
            w_byte_code = ST_NUL;
        end else if (w_byte == "\\") begin
            w_byte_code = ST_BACKSLASH;
        end else if (r_target_windows && w_win_bad) begin
            w_byte_code = ST_BAD_CHAR;
        end else begin
            w_byte_code = ST_OK;
        end
    end

    // segment and stem tracking for one byte
    always_comb begin
        w_upd_seg_len      = r_seg_len;
        w_upd_all_dots     = r_all_dots;
        w_upd_stem_chars   = r_stem_chars;
        w_upd_stem_len     = r_stem_len;
        w_upd_stem_closed  = r_stem_closed;
        w_upd_prev_byte    = r_prev_byte;
        w_upd_first_letter = r_first_letter;
        if (w_is_slash) begin
            // slash opens a new segment
            w_upd_seg_len     = 3'd0;
            w_upd_all_dots    = 1'b1;
            w_upd_stem_len    = 3'd0;
            w_upd_stem_closed = 1'b0;
        end else begin
            if (r_seg_len != 3'd7) begin
                w_upd_seg_len = r_seg_len + 3'd1;
            end
            if (!w_is_dot) begin
                w_upd_all_dots = 1'b0;
            end
            if (!r_stem_closed) begin
                if (w_is_dot) begin
                    w_upd_stem_closed = 1'b1;
                end else if (r_stem_len < 3'd5) begin
                    if (r_stem_len < 3'd4) begin
                        w_upd_stem_chars[r_stem_len[1:0]] = w_upper;
                    end
                    w_upd_stem_len = r_stem_len + 3'd1;
                end
            end
            if (r_name_pos == 2'd0) begin
                w_upd_first_letter = w_is_letter;
            end
            w_upd_prev_byte = w_byte;
        end
    end

    // a slash closes the segment seen so far, a last byte closes the updated one
    always_comb begin
        if (w_is_slash) begin
            w_seg.seg_len    = r_seg_len;
            w_seg.all_dots   = r_all_dots;
            w_seg.stem_len   = r_stem_len;
            w_seg.stem_chars = r_stem_chars;
            w_seg.last_char  = r_prev_byte;
        end else begin
            w_seg.seg_len    = w_upd_seg_len;
            w_seg.all_dots   = w_upd_all_dots;
            w_seg.stem_len   = w_upd_stem_len;
            w_seg.stem_chars = w_upd_stem_chars;
            w_seg.last_char  = w_upd_prev_byte;
        end
    end

    apnc_seg_rules u_seg_rules (
        .i_seg            (w_seg),
        .i_target_windows (r_target_windows),
        .o_code           (w_seg_code)
    );

    // first-error latch and end-of-name handling
    always_comb begin
        n_first_error  = r_first_error;
        n_name_pos     = r_name_pos;
        n_first_letter = w_upd_first_letter;
        n_seg_len      = w_upd_seg_len;
        n_all_dots     = w_upd_all_dots;
        n_stem_chars   = w_upd_stem_chars;
        n_stem_len     = w_upd_stem_len;
        n_stem_closed  = w_upd_stem_closed;
        n_prev_byte    = w_upd_prev_byte;
        n_out_req      = '{status: ST_EMPTY, is_directory: 1'b0};

        if (!i_in_req.empty_entry) begin
            if (w_is_slash) begin
                if (r_name_pos == 2'd0) begin
                    // lone slash is an empty directory name, a leading one is absolute
                    if (n_first_error == ST_OK) begin
                        n_first_error = i_in_req.last_byte ? ST_EMPTY_DIR : ST_ABSOLUTE;
                    end
                end else if (n_first_error == ST_OK) begin
                    n_first_error = w_seg_code;
                end
            end else begin
                if (n_first_error == ST_OK) begin
                    n_first_error = w_byte_code;
                end
                if (i_in_req.last_byte && (n_first_error == ST_OK)) begin
                    n_first_error = w_seg_code;
                end
            end
            if (r_name_pos != 2'd2) begin
                n_name_pos = r_name_pos + 2'd1;
            end
            n_out_req = '{status: n_first_error, is_directory: w_is_slash};
        end

        // a verdict starts a fresh name
        if (w_result) begin
            n_first_error  = ST_OK;
            n_name_pos     = 2'd0;
            n_first_letter = 1'b0;
            n_seg_len      = 3'd0;
            n_all_dots     = 1'b1;
            n_stem_len     = 3'd0;
            n_stem_closed  = 1'b0;
            n_prev_byte    = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_windows <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target_windows <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_error  <= ST_OK;
            r_name_pos     <= 2'd0;
            r_first_letter <= 1'b0;
            r_seg_len      <= 3'd0;
            r_all_dots     <= 1'b1;
            r_stem_len     <= 3'd0;
            r_stem_closed  <= 1'b0;
            r_prev_byte    <= 8'h00;
        end else if (w_accept) begin
            r_first_error  <= n_first_error;
            r_name_pos     <= n_name_pos;
            r_first_letter <= n_first_letter;
            r_seg_len      <= n_seg_len;
            r_all_dots     <= n_all_dots;
            r_stem_len     <= n_stem_len;
            r_stem_closed  <= n_stem_closed;
            r_prev_byte    <= n_prev_byte;
        end
    end

    // stem store: entries are only read after being written
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stem_chars <= n_stem_chars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_result) begin
            r_out_req <= n_out_req;
        end
    end

endmodule

// ===== rtl/core/apnc_seg_rules.sv =====
module apnc_seg_rules (
    input  apnc_pkg::t_seg_info i_seg,
    input  logic                i_target_windows,
    output logic [3:0]          o_code
);
    import apnc_pkg::*;

    logic [23:0] w_stem3;
    logic        w_reserved;

    assign w_stem3 = {i_seg.stem_chars[0], i_seg.stem_chars[1], i_seg.stem_chars[2]};

    always_comb begin
        w_reserved = 1'b0;
        if (i_seg.stem_len == 3'd3) begin
            w_reserved = (w_stem3 == "CON") || (w_stem3 == "PRN") ||
                         (w_stem3 == "AUX") || (w_stem3 == "NUL");
        end else if (i_seg.stem_len == 3'd4) begin
            w_reserved = ((w_stem3 == "COM") || (w_stem3 == "LPT")) &&
                         (i_seg.stem_chars[3] >= "1") && (i_seg.stem_chars[3] <= "9");
        end
    end

    always_comb begin
        priority if (i_seg.seg_len == 3'd0) begin
            o_code = ST_EMPTY_SEG;
        end else if (i_seg.all_dots && (i_seg.seg_len <= 3'd2)) begin
            o_code = ST_DOT_SEG;
        end else if (i_target_windows &&
                     ((i_seg.last_char == ".") || (i_seg.last_char == " "))) begin
            o_code = ST_TRAILING;
        end else if (i_target_windows && w_reserved) begin
            o_code = ST_RESERVED;
        end else begin
            o_code = ST_OK;
        end
    end

endmodule

// ===== rtl/core/apnc_checker.sv =====
module apnc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input apnc_pkg::t_in_req  i_in_req,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input apnc_pkg::t_out_req o_out_req
);
    import apnc_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    // an empty entry gives an empty verdict next cycle
    a_empty_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_req.empty_entry |=>
            o_out_valid && (o_out_req.status == ST_EMPTY) && !o_out_req.is_directory)
        else $error("empty entry did not give an empty verdict");

    // a byte that ends no name creates no verdict
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_in_req.empty_entry && !i_in_req.last_byte &&
        !(o_out_valid && !i_out_ready) |=> !o_out_valid)
        else $error("verdict without a last byte");

    // a trailing slash marks a directory
    a_dir_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_in_req.empty_entry && i_in_req.last_byte &&
        (i_in_req.name_byte == "/") |=> o_out_valid && o_out_req.is_directory)
        else $error("trailing slash not flagged as directory");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.status <= ST_RESERVED))
        else $error("status code out of range");

endmodule

bind archive_path_name_checker apnc_checker u_apnc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

// ===== tb/archive_path_name_checker_test.sv =====
`timescale 1ns / 1ps

module archive_path_name_checker_test;
    import apnc_pkg::*;

    // run limit, far above the slowest correct run of about 1200 requests
    localparam int CYCLE_LIMIT = 200000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_req = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_req o_out_req;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    logic     i_cfg_data = 1'b0;

    archive_path_name_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // name bytes waiting to be sent, and verdicts still owed by the block
    t_in_req  name_bytes_pending [$];
    t_out_req verdicts_due [$];
    t_out_req verdict_want;

    int gap_pct = 24;          // chance in a hundred that a side idles this cycle
    int mismatches = 0;
    int cycle_count = 0;
    int queued_bytes = 0;
    int bytes_sent = 0;
    int names_checked = 0;
    bit status_seen [16];

    string device_stems [6] = '{"CON", "PRN", "AUX", "NUL", "COM", "LPT"};

    // ---------------------------------------------------------------
    // name checker prediction: own copy of mode and per-name state
    // ---------------------------------------------------------------
    logic       win_mode = 1'b0;
    logic [3:0] nm_err;
    int         nm_pos;
    bit         nm_first_letter;
    int         seg_len;
    bit         seg_dots;
    logic [7:0] stem [STEM_DEPTH];
    int         stem_len;
    bit         stem_done;
    logic [7:0] prev_char;

    task automatic latch_error(logic [3:0] code);
        if (nm_err == ST_OK) nm_err = code;
    endtask

    task automatic open_segment();
        seg_len = 0;
        seg_dots = 1'b1;
        stem_len = 0;
        stem_done = 1'b0;
    endtask

    task automatic clear_name();
        nm_err = ST_OK;
        nm_pos = 0;
        nm_first_letter = 1'b0;
        prev_char = 8'h00;
        open_segment();
    endtask

    function automatic bit stem_is(string s);
        for (int i = 0; i < s.len(); i++)
            if (stem[i] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit stem_reserved();
        if (stem_len == 3)
            return stem_is("CON") || stem_is("PRN") || stem_is("AUX") || stem_is("NUL");
        if (stem_len == 4 && (stem_is("COM") || stem_is("LPT")))
            return stem[3] >= "1" && stem[3] <= "9";
        return 1'b0;
    endfunction

    // end-of-segment rules: empty, dot segments, then the windows-only ones
    task automatic close_segment();
        if (seg_len == 0) begin
            latch_error(ST_EMPTY_SEG);
        end else if (seg_dots && seg_len <= 2) begin
            latch_error(ST_DOT_SEG);
        end else if (win_mode) begin
            if (prev_char == "." || prev_char == " ") latch_error(ST_TRAILING);
            else if (stem_reserved()) latch_error(ST_RESERVED);
        end
    endtask

    function automatic bit windows_forbidden(logic [7:0] b);
        return b < 8'h20 || b == "<" || b == ">" || b == ":" || b == "\"" || b == "|" ||
               b == "?" || b == "*";
    endfunction

    task automatic predict_request(t_in_req r);
        logic [7:0] b;
        t_out_req   v;
        b = r.name_byte;
        if (r.empty_entry) begin
            // zero-length name drops whatever partial name was in progress
            clear_name();
            v.status = ST_EMPTY;
            v.is_directory = 1'b0;
            verdicts_due.push_back(v);
            return;
        end
        if (b == "/") begin
            if (nm_pos == 0) latch_error(r.last_byte ? ST_EMPTY_DIR : ST_ABSOLUTE);
            else close_segment();
            open_segment();
        end else begin
            // drive prefix wins over the windows colon rule by coming first
            if (nm_pos == 1 && b == ":" && nm_first_letter) latch_error(ST_DRIVE);
            if (b == 8'h00) latch_error(ST_NUL);
            else if (b == "\\") latch_error(ST_BACKSLASH);
            else if (win_mode && windows_forbidden(b)) latch_error(ST_BAD_CHAR);
            if (seg_len < 7) seg_len++;
            if (b != ".") seg_dots = 1'b0;
            if (!stem_done) begin
                if (b == ".") begin
                    stem_done = 1'b1;
                end else if (stem_len < 5) begin
                    // fold a-z only, stems past four bytes just count
                    if (stem_len < STEM_DEPTH)
                        stem[stem_len] = (b >= "a" && b <= "z") ? b - 8'd32 : b;
                    stem_len++;
                end
            end
            if (nm_pos == 0)
                nm_first_letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
            prev_char = b;
        end
        if (nm_pos < 2) nm_pos++;
        if (r.last_byte) begin
            if (b != "/") close_segment();
            v.status = nm_err;
            v.is_directory = (b == "/");
            verdicts_due.push_back(v);
            clear_name();
        end
    endtask

    // ---------------------------------------------------------------
    // mismatch reporting
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    task automatic push_request(logic [7:0] b, logic last, logic empty);
        t_in_req r;
        r.name_byte = b;
        r.last_byte = last;
        r.empty_entry = empty;
        name_bytes_pending.push_back(r);
        queued_bytes++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_request(s[i], i == s.len() - 1, 1'b0);
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'($urandom_range("A", "Z"));
        return $urandom_range(0, 1) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] random_case(logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) return c + 8'd32;
        return c;
    endfunction

    // mostly ordinary file name characters, with a share of troublesome ones
    function automatic logic [7:0] random_name_char();
        int    pick;
        string odd;
        string bad;
        odd = " .-_";
        bad = "<>:\"|?*\\";
        pick = $urandom_range(0, 99);
        if (pick < 60) return random_letter();
        if (pick < 72) return 8'($urandom_range("0", "9"));
        if (pick < 84) return odd[$urandom_range(0, odd.len() - 1)];
        if (pick < 93) return bad[$urandom_range(0, bad.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random_name();
        logic [7:0] nb [$];
        int         kind;
        int         nseg;
        int         len;
        int         pick;
        int         s;
        int         i;
        string      word;
        kind = $urandom_range(0, 99);
        if (kind < 7) begin
            // zero-length name, the other payload bits are don't-care
            push_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        if (kind < 15) begin
            // raw noise bytes
            len = $urandom_range(1, 9);
            repeat (len) nb.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 9) == 0) nb.push_back("/");
            if ($urandom_range(0, 9) == 0) begin
                nb.push_back(random_letter());
                nb.push_back(":");
            end
            nseg = $urandom_range(1, 3);
            for (s = 0; s < nseg; s++) begin
                if (s > 0) nb.push_back("/");
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    // device stem in mixed case, maybe a digit, extra letter or extension
                    word = device_stems[$urandom_range(0, 5)];
                    for (i = 0; i < word.len(); i++) nb.push_back(random_case(word[i]));
                    if (word == "COM" || word == "LPT")
                        nb.push_back(8'($urandom_range("0", "9")));
                    if ($urandom_range(0, 5) == 0) nb.push_back(random_letter());
                    if ($urandom_range(0, 1)) begin
                        nb.push_back(".");
                        len = $urandom_range(0, 3);
                        repeat (len) nb.push_back(random_letter());
                    end
                end else if (pick < 35) begin
                    len = $urandom_range(1, 3);
                    repeat (len) nb.push_back(".");
                end else if (pick < 39) begin
                    // empty segment
                end else begin
                    len = $urandom_range(1, 10);
                    repeat (len) nb.push_back(random_name_char());
                end
                if ($urandom_range(0, 9) == 0) nb.push_back($urandom_range(0, 1) ? "." : " ");
            end
            if ($urandom_range(0, 5) == 0) nb.push_back("/");
        end
        if (nb.size() > 1 && $urandom_range(0, 19) == 0) begin
            // name cut short by a zero-length entry
            len = $urandom_range(1, nb.size() - 1);
            for (i = 0; i < len; i++) push_request(nb[i], 1'b0, 1'b0);
            push_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        for (i = 0; i < nb.size(); i++) push_request(nb[i], i == nb.size() - 1, 1'b0);
    endtask

    // ---------------------------------------------------------------
    // driver: feeds name bytes from the pending queue, predicts on accept
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_request(i_in_req);
                if (!i_in_req.empty_entry) bytes_sent++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the request until taken
            end else if (name_bytes_pending.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                i_in_valid <= 1'b1;
                i_in_req <= name_bytes_pending.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: compares each verdict with the oldest one owed
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                names_checked++;
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("verdict status %0d with none owed",
                                              o_out_req.status));
                end else begin
                    verdict_want = verdicts_due.pop_front();
                    status_seen[verdict_want.status] = 1'b1;
                    if (o_out_req.status !== verdict_want.status)
                        report_mismatch($sformatf("name %0d status %0d, want %0d",
                                                  names_checked, o_out_req.status,
                                                  verdict_want.status));
                    if (o_out_req.is_directory !== verdict_want.is_directory)
                        report_mismatch($sformatf("name %0d is_directory %0b, want %0b",
                                                  names_checked, o_out_req.is_directory,
                                                  verdict_want.is_directory));
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= gap_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts owed", cycle_count,
                     verdicts_due.size());
            $display("** archive_path_name_checker: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequencing
    // ---------------------------------------------------------------

    // waits until every name byte is sent and every owed verdict is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (name_bytes_pending.size() != 0 || i_in_valid || verdicts_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_mode = v;
    endtask

    task automatic random_phase(logic mode, int gaps);
        int stop_at;
        wait_idle();
        write_mode(mode);
        gap_pct = gaps;
        stop_at = queued_bytes + 275;
        while (queued_bytes < stop_at) queue_random_name();
    endtask

    initial begin
        int codes;
        clear_name();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed, portable rules
        write_mode(1'b0);
        push_request(8'hA5, 1'b1, 1'b1);        // zero-length name
        queue_text("/");                        // lone slash
        queue_text("/a");                       // leading slash
        queue_text("c:");                       // drive prefix
        queue_text("a//");                      // empty segment, directory
        queue_text("..");                       // dot segment
        push_request(8'h00, 1'b1, 1'b0);        // NUL byte
        queue_text("\\");                       // backslash
        push_request(8'hFF, 1'b1, 1'b0);        // top byte value is fine here
        queue_text("d/");                       // plain directory
        push_request("a", 1'b0, 1'b0);          // zero-length entry mid name
        push_request(8'h5A, 1'b0, 1'b1);

        // directed, windows rules
        wait_idle();
        write_mode(1'b1);
        queue_text("x?");                       // forbidden character
        queue_text("a.");                       // trailing dot
        queue_text("con");                      // reserved stem, folded case
        queue_text("Lpt9");                     // numbered device
        queue_text("C:");                       // drive beats the colon rule

        // random names, one stretch with no idling on either side
        random_phase(1'b1, 24);
        random_phase(1'b0, 24);
        random_phase(1'b1, 0);
        random_phase(1'b0, 24);
        gap_pct = 24;
        wait_idle();

        codes = 0;
        foreach (status_seen[i]) codes += status_seen[i];
        $display("checked %0d names over %0d name bytes, windows rules on and off",
                 names_checked, bytes_sent);
        $display("verdict codes reached: %0d of 12", codes);
        if (mismatches == 0) begin
            $display("** archive_path_name_checker: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** archive_path_name_checker: FAILED **");
        end
        $finish;
    end

endmodule
